// File: rtl/conv3x3_clamped_edge_unit_defines.svh
// ---------------------------------------------------------------------------
// conv3x3_clamped_edge_unit assertion macros
// Shared property shapes for the 3x3 convolution unit checks.
// ---------------------------------------------------------------------------
`ifndef CONV3X3_CLAMPED_EDGE_UNIT_DEFINES_SVH
`define CONV3X3_CLAMPED_EDGE_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define C3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger
`define C3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/conv3_pkg.sv
// ---------------------------------------------------------------------------
// conv3_pkg
// Sizes, codes and kernel weights of the 3x3 image convolution unit.
// ---------------------------------------------------------------------------
package conv3_pkg;

	// Image limits
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 4;
	localparam int ROW_SAMPLES  = MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W       = $clog2(ROW_SAMPLES);

	// Register and field widths
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 13;
	localparam int CHAN_W      = 3;
	localparam int KSEL_W      = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int SAMPLE_W    = 8;

	// Counter widths
	localparam int X_W    = $clog2(MAX_WIDTH);
	localparam int CIDX_W = 2;
	localparam int SPAN_W = $clog2(ROW_SAMPLES + 1);
	localparam int LAG_W  = $clog2(ROW_SAMPLES + MAX_CHANNELS);

	// Window: newest row keeps offsets 0 .. 2*channels
	localparam int WIN_TAPS = 2 * MAX_CHANNELS + 1;

	// Arithmetic
	localparam int SUM_W      = 13;
	localparam int KW_W       = 4;
	localparam int DIV9_RECIP = 7282;
	localparam int DIV9_SHIFT = 16;
	localparam int PROD_W     = 25;
	localparam int GAUSS_SHIFT = 4;

	// Kernel codes
	typedef enum logic [KSEL_W-1:0] {
		KERN_EDGE     = 3'd0,
		KERN_SHARPEN  = 3'd1,
		KERN_BOX      = 3'd2,
		KERN_GAUSS    = 3'd3,
		KERN_EMBOSS   = 3'd4,
		KERN_IDENTITY = 3'd5
	} kern_t;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNELS      = 2'd2,
		REG_KERNEL_SELECT = 2'd3
	} reg_index_t;

	// Item commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	// Kernel weights, row major, top row first, left column first
	localparam logic signed [KW_W-1:0] KERN_TAB [6][9] = '{
		'{ 4'sd0, -4'sd1,  4'sd0, -4'sd1,  4'sd4, -4'sd1,  4'sd0, -4'sd1,  4'sd0},
		'{ 4'sd0, -4'sd1,  4'sd0, -4'sd1,  4'sd5, -4'sd1,  4'sd0, -4'sd1,  4'sd0},
		'{ 4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1,  4'sd1},
		'{ 4'sd1,  4'sd2,  4'sd1,  4'sd2,  4'sd4,  4'sd2,  4'sd1,  4'sd2,  4'sd1},
		'{-4'sd2, -4'sd1,  4'sd0, -4'sd1,  4'sd1,  4'sd1,  4'sd0,  4'sd1,  4'sd2},
		'{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd0}
	};

	// Border flags of one output sample
	typedef struct packed {
		logic left_edge;
		logic right_edge;
		logic top_edge;
		logic bottom_edge;
		logic last;
	} edge_flags_t;

endpackage

// File: rtl/conv3x3_clamped_edge_unit.sv
// ---------------------------------------------------------------------------
// conv3x3_clamped_edge_unit
// Streaming 3x3 convolution over an interleaved raster image with the
// border samples repeated; two line memories and a tap window per row.
// ---------------------------------------------------------------------------
// Throughput: one item per clock while the output side does not stall.
// Pipeline: the item that completes a neighborhood (one row plus one pixel
//   after its sample) goes through the tap, sum and output registers.
// Reset: control, counters and handshake clear at once; line memories and
//   window taps hold unknown data until written, and need no clearing pass.
`include "conv3x3_clamped_edge_unit_defines.svh"

module conv3x3_clamped_edge_unit import conv3_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [SAMPLE_W-1:0]    sample_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_W-1:0]    out_value,
	output logic                   last
);

	// Configuration registers
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [KSEL_W-1:0]   ksel_q;

	// Effective geometry
	logic [WIDTH_W-1:0]  w_eff;
	logic [X_W-1:0]      w_m1;
	logic [HEIGHT_W-1:0] h_m1;
	logic [CHAN_W-1:0]   c_eff;
	logic [CIDX_W-1:0]   ch_m1;
	logic [SPAN_W-1:0]   span;
	logic [SPAN_W-1:0]   span_m1;
	logic                span_one;
	logic [LAG_W-1:0]    lag_m1;
	kern_t               kern_eff;

	// Stream position
	logic [CIDX_W-1:0]   in_c_q;
	logic [X_W-1:0]      in_x_q;
	logic [HEIGHT_W-1:0] in_y_q;
	logic                in_done_q;
	logic [CIDX_W-1:0]   out_c_q;
	logic [X_W-1:0]      out_x_q;
	logic [HEIGHT_W-1:0] out_y_q;
	logic                out_on_q;
	logic [LAG_W-1:0]    pos_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [ADDR_W-1:0]   ptr_prev_q;

	// Line memories and window taps
	logic [SAMPLE_W-1:0] row_a_q [ROW_SAMPLES];
	logic [SAMPLE_W-1:0] row_b_q [ROW_SAMPLES];
	logic [SAMPLE_W-1:0] rd_a_q;
	logic [SAMPLE_W-1:0] rd_b_q;
	logic [SAMPLE_W-1:0] win2_q [WIN_TAPS];
	logic [SAMPLE_W-1:0] win1_q [WIN_TAPS-1];
	logic [SAMPLE_W-1:0] win0_q [WIN_TAPS-1];
	logic [SAMPLE_W-1:0] head0;
	logic [SAMPLE_W-1:0] taps [3][WIN_TAPS];
	logic [SAMPLE_W-1:0] cur_px [3];
	logic [SAMPLE_W-1:0] mid_px [3];
	logic [SAMPLE_W-1:0] far_px [3];
	logic [SAMPLE_W-1:0] colv [3][3];
	logic [SAMPLE_W-1:0] nbr [3][3];
	logic [SUM_W-1:0]    acc;

	// Handshake and pipeline
	logic                in_acc;
	logic                drop;
	logic                adv;
	logic                store;
	logic                emit;
	logic                emit_last;
	logic                in_at_end;
	logic                out_at_end;
	logic                s1_valid_q;
	logic                s1_move;
	edge_flags_t         flags_s1;
	logic                s2_valid_q;
	logic                s2_move;
	logic signed [SUM_W-1:0] sum_s2;
	logic                last_s2;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_value_q;
	logic                last_q;
	logic [PROD_W-1:0]   quot_prod;
	logic signed [SUM_W-1:0] post;
	logic [SAMPLE_W-1:0] sat;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
			chan_q   <= CHAN_W'(1);
			ksel_q   <= KERN_IDENTITY;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[HEIGHT_W-1:0];
				REG_CHANNELS:      chan_q   <= cfg_data[CHAN_W-1:0];
				REG_KERNEL_SELECT: ksel_q   <= cfg_data[KSEL_W-1:0];
				default:           width_q  <= width_q;
			endcase
		end
	end

	// Clamp the registers to usable geometry
	always_comb begin
		priority if (width_q == '0)
			w_eff = WIDTH_W'(1);
		else if (width_q > WIDTH_W'(MAX_WIDTH))
			w_eff = WIDTH_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		priority if (chan_q == '0)
			c_eff = CHAN_W'(1);
		else if (chan_q > CHAN_W'(MAX_CHANNELS))
			c_eff = CHAN_W'(MAX_CHANNELS);
		else
			c_eff = chan_q;
		w_m1     = X_W'(w_eff - WIDTH_W'(1));
		h_m1     = (height_q == '0) ? '0 : height_q - HEIGHT_W'(1);
		ch_m1    = CIDX_W'(c_eff - CHAN_W'(1));
		span     = SPAN_W'(w_eff) * SPAN_W'(c_eff);
		span_m1  = span - SPAN_W'(1);
		span_one = (span == SPAN_W'(1));
		lag_m1   = LAG_W'(span) + LAG_W'(c_eff) - LAG_W'(1);
		kern_eff = (ksel_q > KERN_IDENTITY) ? KERN_IDENTITY : kern_t'(ksel_q);
	end

	// Handshake: a new item may enter once the tap stage is free or moving
	assign s2_move  = s2_valid_q && (!out_valid_q || out_ready);
	assign s1_move  = s1_valid_q && (!s2_valid_q || s2_move);
	assign in_ready = !s1_valid_q || s1_move;
	assign in_acc   = in_valid && in_ready;

	// Drop a drain before the image is complete; otherwise advance the stream
	assign drop       = !in_done_q && (cmd == CMD_DRAIN);
	assign adv        = in_acc && !drop;
	assign store      = adv && !in_done_q;
	assign emit       = adv && out_on_q;
	assign in_at_end  = (in_c_q == ch_m1) && (in_x_q == w_m1) && (in_y_q == h_m1);
	assign out_at_end = (out_c_q == ch_m1) && (out_x_q == w_m1) && (out_y_q == h_m1);
	assign emit_last  = emit && out_at_end;

	// Stream position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_c_q    <= '0;
			in_x_q    <= '0;
			in_y_q    <= '0;
			in_done_q <= 1'b0;
			out_c_q   <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_on_q  <= 1'b0;
			pos_q     <= '0;
			ptr_q     <= '0;
		end else if (cfg_we || emit_last) begin
			in_c_q    <= '0;
			in_x_q    <= '0;
			in_y_q    <= '0;
			in_done_q <= 1'b0;
			out_c_q   <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_on_q  <= 1'b0;
			pos_q     <= '0;
			ptr_q     <= '0;
		end else if (adv) begin
			// wrap the line pointer at one row of samples
			if (ptr_q == ADDR_W'(span_m1))
				ptr_q <= '0;
			else
				ptr_q <= ptr_q + ADDR_W'(1);
			if (store) begin
				if (in_at_end)
					in_done_q <= 1'b1;
				if (in_c_q == ch_m1) begin
					in_c_q <= '0;
					if (in_x_q == w_m1) begin
						in_x_q <= '0;
						in_y_q <= in_y_q + HEIGHT_W'(1);
					end else begin
						in_x_q <= in_x_q + X_W'(1);
					end
				end else begin
					in_c_q <= in_c_q + CIDX_W'(1);
				end
			end
			// results start one row plus one pixel into the stream
			if (!out_on_q) begin
				if (pos_q == lag_m1)
					out_on_q <= 1'b1;
				else
					pos_q <= pos_q + LAG_W'(1);
			end
			if (emit) begin
				if (out_c_q == ch_m1) begin
					out_c_q <= '0;
					if (out_x_q == w_m1) begin
						out_x_q <= '0;
						out_y_q <= out_y_q + HEIGHT_W'(1);
					end else begin
						out_x_q <= out_x_q + X_W'(1);
					end
				end else begin
					out_c_q <= out_c_q + CIDX_W'(1);
				end
			end
		end
	end

	// Oldest row: with a one-sample row the memory is bypassed by the tap chain
	assign head0 = span_one ? win1_q[0] : rd_b_q;

	// Line memories and tap chains
	always_ff @(posedge clk) begin
		if (adv) begin
			ptr_prev_q       <= ptr_q;
			row_a_q[ptr_q]   <= sample_value;
			rd_a_q           <= row_a_q[ptr_q];
			row_b_q[ptr_prev_q] <= rd_a_q;
			rd_b_q           <= row_b_q[ptr_q];
			win2_q[0]        <= sample_value;
			win1_q[0]        <= rd_a_q;
			win0_q[0]        <= head0;
			for (int k = 1; k < WIN_TAPS; k++)
				win2_q[k] <= win2_q[k-1];
			for (int k = 1; k < WIN_TAPS - 1; k++) begin
				win1_q[k] <= win1_q[k-1];
				win0_q[k] <= win0_q[k-1];
			end
		end
	end

	// Tap view per row: row 2 is below, row 1 is the center row, row 0 above
	always_comb begin
		for (int k = 0; k < WIN_TAPS; k++)
			taps[2][k] = win2_q[k];
		taps[1][0] = rd_a_q;
		taps[0][0] = head0;
		for (int k = 1; k < WIN_TAPS; k++) begin
			taps[1][k] = win1_q[k-1];
			taps[0][k] = win0_q[k-1];
		end
	end

	// Pick the pixel columns of each row, repeating the center at the borders
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			cur_px[r] = taps[r][0];
			unique case (ch_m1)
				2'd0: begin
					mid_px[r] = taps[r][1];
					far_px[r] = taps[r][2];
				end
				2'd1: begin
					mid_px[r] = taps[r][2];
					far_px[r] = taps[r][4];
				end
				2'd2: begin
					mid_px[r] = taps[r][3];
					far_px[r] = taps[r][6];
				end
				default: begin
					mid_px[r] = taps[r][4];
					far_px[r] = taps[r][8];
				end
			endcase
			colv[r][0] = flags_s1.left_edge ? mid_px[r] : far_px[r];
			colv[r][1] = mid_px[r];
			colv[r][2] = flags_s1.right_edge ? mid_px[r] : cur_px[r];
		end
		for (int j = 0; j < 3; j++) begin
			nbr[0][j] = flags_s1.top_edge ? colv[1][j] : colv[0][j];
			nbr[1][j] = colv[1][j];
			nbr[2][j] = flags_s1.bottom_edge ? colv[1][j] : colv[2][j];
		end
	end

	// Weighted sum of the neighborhood
	always_comb begin
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = acc + {{(SUM_W-SAMPLE_W){1'b0}}, nbr[i][j]}
					* {{(SUM_W-KW_W){KERN_TAB[kern_eff][i*3+j][KW_W-1]}},
					KERN_TAB[kern_eff][i*3+j]};
			end
		end
	end

	// Tap stage: hold the border flags of the item whose window is in the taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= emit;
		else if (s1_move)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			flags_s1.left_edge   <= (out_x_q == '0);
			flags_s1.right_edge  <= (out_x_q == w_m1);
			flags_s1.top_edge    <= (out_y_q == '0);
			flags_s1.bottom_edge <= (out_y_q == h_m1);
			flags_s1.last        <= out_at_end;
		end
	end

	// Sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid_q <= 1'b0;
		else if (s1_move)
			s2_valid_q <= 1'b1;
		else if (s2_move)
			s2_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			sum_s2  <= $signed(acc);
			last_s2 <= flags_s1.last;
		end
	end

	// Scale by kernel, then saturate to the sample range
	assign quot_prod = PROD_W'(sum_s2[SUM_W-2:0]) * PROD_W'(DIV9_RECIP);

	always_comb begin
		unique case (kern_eff)
			KERN_BOX:   post = SUM_W'(quot_prod >> DIV9_SHIFT);
			KERN_GAUSS: post = sum_s2 >>> GAUSS_SHIFT;
			default:    post = sum_s2;
		endcase
		priority if (post[SUM_W-1])
			sat = '0;
		else if (|post[SUM_W-2:SAMPLE_W])
			sat = '1;
		else
			sat = post[SAMPLE_W-1:0];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s2_move)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_value_q <= sat;
			last_q      <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	// Checks
	`C3_ASSERT_NEXT(a_end_clears, emit_last, (pos_q == '0) && !out_on_q && !in_done_q, "image end did not clear the stream position")
	`C3_ASSERT_NOW(a_ptr_in_row, 1'b1, SPAN_W'(ptr_q) <= span_m1, "line pointer beyond the row length")
	`C3_ASSERT_NOW(a_lag_bound, !out_on_q, pos_q <= lag_m1, "start counter passed the row lag")
	`C3_ASSERT_NEXT(a_sum_held, s2_valid_q && !s2_move, s2_valid_q && $stable(sum_s2), "stalled sum stage lost its item")

endmodule
